### hdl/ptc_pkg.sv
`default_nettype none
package ptc_pkg;

   localparam int unsigned DataWidth  = 32;
   localparam int unsigned RawWidth   = 19;
   localparam int unsigned ValueWidth = 18;
   localparam int unsigned AddrWidth  = 5;

   localparam logic [1:0] STATUS_OK     = 2'd0;
   localparam logic [1:0] STATUS_NO_TMP = 2'd1;
   localparam logic [1:0] STATUS_DIV0   = 2'd2;

   localparam logic [2:0] REG_OSS   = 3'd0;
   localparam logic [2:0] REG_AC12  = 3'd1;
   localparam logic [2:0] REG_AC34  = 3'd2;
   localparam logic [2:0] REG_AC5   = 3'd3;
   localparam logic [2:0] REG_AC6   = 3'd4;
   localparam logic [2:0] REG_B12   = 3'd5;
   localparam logic [2:0] REG_MC    = 3'd6;
   localparam logic [2:0] REG_MD    = 3'd7;

   typedef enum logic [4:0] {
      ST_IDLE, ST_T1, ST_T2, ST_TDIV, ST_TFIN,
      ST_P1, ST_P2, ST_P3, ST_P4, ST_P5, ST_P6, ST_P7, ST_P8, ST_P9,
      ST_PDIV, ST_P10, ST_P11, ST_P12, ST_OUT
   } state_type;

   typedef struct packed {
      logic busy;
      logic done;
   } div_stat_type;

   function automatic logic [31:0] sx16(input logic [15:0] v);
      return {{16{v[15]}}, v};
   endfunction

   function automatic logic [31:0] asr32(input logic [31:0] x, input logic [4:0] s);
      return 32'($signed(x) >>> s);
   endfunction

   function automatic logic [17:0] sat18(input logic [31:0] x);
      logic signed [31:0] s;
      s = $signed(x);
      if (s > 32'sd131071) return 18'h1FFFF;
      if (s < -32'sd131072) return 18'h20000;
      return x[17:0];
   endfunction

endpackage
`default_nettype wire

### hdl/ptc_div.sv
`default_nettype none
module ptc_div (
   input  wire logic                    clock,
   input  wire logic                    reset,
   input  wire logic                    start,
   input  wire logic [31:0]             num,
   input  wire logic [31:0]             den,
   output      ptc_pkg::div_stat_type   stat,
   output      logic [31:0]             quo
);
   import ptc_pkg::*;

   // restoring divider, one quotient bit a cycle
   logic [32:0] rem_ff, rem_in;
   logic [31:0] quo_ff, quo_in, den_ff, den_in;
   logic [4:0]  cnt_ff, cnt_in;
   logic        busy_ff, busy_in, done_ff, done_in;
   logic [32:0] rem_sh, diff;
   logic        ge;

   always_comb begin
      rem_sh  = {rem_ff[31:0], quo_ff[31]};
      diff    = rem_sh - {1'b0, den_ff};
      ge      = !diff[32];
      rem_in  = rem_ff;
      quo_in  = quo_ff;
      den_in  = den_ff;
      cnt_in  = cnt_ff;
      busy_in = busy_ff;
      done_in = 1'b0;
      if (start) begin
         rem_in  = '0;
         quo_in  = num;
         den_in  = den;
         cnt_in  = '0;
         busy_in = 1'b1;
      end else if (busy_ff) begin
         rem_in = ge ? diff : rem_sh;
         quo_in = {quo_ff[30:0], ge};
         cnt_in = cnt_ff + 5'd1;
         if (cnt_ff == 5'd31) begin
            busy_in = 1'b0;
            done_in = 1'b1;
         end
      end
   end

   always_ff @(posedge clock) begin
      rem_ff <= rem_in;
      quo_ff <= quo_in;
      den_ff <= den_in;
      cnt_ff <= cnt_in;
      if (reset) begin
         busy_ff <= 1'b0;
         done_ff <= 1'b0;
      end else begin
         busy_ff <= busy_in;
         done_ff <= done_in;
      end
   end

   assign stat.busy = busy_ff;
   assign stat.done = done_ff;
   assign quo       = quo_ff;

endmodule
`default_nettype wire

### hdl/pressure_temp_compensation.sv
`default_nettype none
// Sequence: a temperature item passes T1, T2, the divider wait and TFIN before rsp_tvalid;
//   a pressure item passes P1 to P9, the divider wait and P10 to P12; an item with an
//   early status (no temperature yet, zero divisor) returns sooner.
// Flow: one item at a time; the next item is accepted only after the result has been taken.
//   A shared 32x32 multiplier and a bit-serial divider do the arithmetic.
// Reset: synchronous, active high; clears calibration registers, stored temperature
//   term and the sequencer.
module pressure_temp_compensation (
   input  wire logic        clock,
   input  wire logic        reset,
   // item in
   input  wire logic        req_tvalid,
   output      logic        req_tready,
   input  wire logic [23:0] req_tdata,   // [18:0] raw_sample, rest zero
   input  wire logic [0:0]  req_tuser,   // [0] command
   // item out
   output      logic        rsp_tvalid,
   input  wire logic        rsp_tready,
   output      logic [23:0] rsp_tdata,   // [17:0] value, rest zero
   output      logic [2:0]  rsp_tuser,   // [0] kind, [2:1] status
   // register port
   input  wire logic                          csr_psel,
   input  wire logic                          csr_penable,
   input  wire logic                          csr_pwrite,
   input  wire logic [ptc_pkg::AddrWidth-1:0] csr_paddr,
   input  wire logic [31:0]                   csr_pwdata,
   output      logic [31:0]                   csr_prdata,
   output      logic                          csr_pready
);
   import ptc_pkg::*;

   // calibration registers
   logic [1:0]  oss_ff;
   logic [31:0] ac12_ff, ac34_ff, b12_ff;
   logic [15:0] ac5_ff, ac6_ff, mc_ff, md_ff;
   logic [2:0]  csr_idx;
   logic        csr_wr;

   assign csr_pready = 1'b1;
   assign csr_idx    = csr_paddr[4:2];
   assign csr_wr     = csr_psel && csr_penable && csr_pwrite;

   always_ff @(posedge clock) begin
      if (reset) begin
         oss_ff  <= '0;
         ac12_ff <= '0;
         ac34_ff <= '0;
         ac5_ff  <= '0;
         ac6_ff  <= '0;
         b12_ff  <= '0;
         mc_ff   <= '0;
         md_ff   <= '0;
      end else if (csr_wr) begin
         case (csr_idx)
            REG_OSS:  oss_ff  <= csr_pwdata[1:0];
            REG_AC12: ac12_ff <= csr_pwdata;
            REG_AC34: ac34_ff <= csr_pwdata;
            REG_AC5:  ac5_ff  <= csr_pwdata[15:0];
            REG_AC6:  ac6_ff  <= csr_pwdata[15:0];
            REG_B12:  b12_ff  <= csr_pwdata;
            REG_MC:   mc_ff   <= csr_pwdata[15:0];
            REG_MD:   md_ff   <= csr_pwdata[15:0];
            default: ;
         endcase
      end
   end

   always_comb begin
      case (csr_idx)
         REG_OSS:  csr_prdata = {30'd0, oss_ff};
         REG_AC12: csr_prdata = ac12_ff;
         REG_AC34: csr_prdata = ac34_ff;
         REG_AC5:  csr_prdata = {16'd0, ac5_ff};
         REG_AC6:  csr_prdata = {16'd0, ac6_ff};
         REG_B12:  csr_prdata = b12_ff;
         REG_MC:   csr_prdata = {16'd0, mc_ff};
         REG_MD:   csr_prdata = {16'd0, md_ff};
         default:  csr_prdata = '0;
      endcase
   end

   // sequencer state and working registers
   state_type   state_ff, state_in;
   logic [31:0] tterm_ff, tterm_in;
   logic        tseen_ff, tseen_in;
   logic [31:0] r1_ff, r1_in;     // x1 / x3 scratch
   logic [31:0] b6_ff, b6_in;
   logic [31:0] sq_ff, sq_in;
   logic [31:0] b3_ff, b3_in;
   logic [31:0] b7_ff, b7_in;
   logic [31:0] b4_ff, b4_in;
   logic [31:0] p_ff, p_in;
   logic        negq_ff, negq_in; // temperature quotient sign
   logic        dbl_ff, dbl_in;   // pressure quotient doubled afterwards
   logic        kind_ff, kind_in;
   logic [18:0] raw_ff, raw_in;
   logic [17:0] value_ff, value_in;
   logic [1:0]  status_ff, status_in;

   // shared multiplier, low word only
   logic [31:0] mul_a, mul_b, prod;
   logic [63:0] mul_full;

   // divider hookup
   logic         div_start;
   logic [31:0]  div_num, div_den, div_quo;
   div_stat_type div_stat;

   logic [31:0] den, num_t, x2, tt, pnew, b3_sum;

   ptc_div u_div (
      .clock (clock),
      .reset (reset),
      .start (div_start),
      .num   (div_num),
      .den   (div_den),
      .stat  (div_stat),
      .quo   (div_quo)
   );

   assign mul_full = mul_a * mul_b;
   assign prod     = mul_full[31:0];

   always_comb begin
      state_in  = state_ff;
      tterm_in  = tterm_ff;
      tseen_in  = tseen_ff;
      r1_in     = r1_ff;
      b6_in     = b6_ff;
      sq_in     = sq_ff;
      b3_in     = b3_ff;
      b7_in     = b7_ff;
      b4_in     = b4_ff;
      p_in      = p_ff;
      negq_in   = negq_ff;
      dbl_in    = dbl_ff;
      kind_in   = kind_ff;
      raw_in    = raw_ff;
      value_in  = value_ff;
      status_in = status_ff;
      mul_a     = '0;
      mul_b     = '0;
      div_start = 1'b0;
      div_num   = '0;
      div_den   = '0;
      den       = r1_ff + sx16(md_ff);
      num_t     = sx16(mc_ff) << 11;
      x2        = '0;
      tt        = '0;
      pnew      = '0;
      b3_sum    = '0;
      req_tready = 1'b0;
      rsp_tvalid = 1'b0;

      case (state_ff)
         ST_IDLE: begin
            req_tready = 1'b1;
            if (req_tvalid) begin
               kind_in   = req_tuser[0];
               raw_in    = req_tdata[18:0];
               status_in = STATUS_OK;
               value_in  = '0;
               if (!req_tuser[0]) begin
                  state_in = ST_T1;
               end else if (!tseen_ff) begin
                  status_in = STATUS_NO_TMP;
                  state_in  = ST_OUT;
               end else begin
                  state_in = ST_P1;
               end
            end
         end
         // x1 = ((ut - ac6) * ac5) >> 15
         ST_T1: begin
            mul_a    = {16'd0, raw_ff[15:0]} - {16'd0, ac6_ff};
            mul_b    = {16'd0, ac5_ff};
            r1_in    = asr32(prod, 5'd15);
            state_in = ST_T2;
         end
         ST_T2: begin
            if (den == '0) begin
               status_in = STATUS_DIV0;
               state_in  = ST_OUT;
            end else begin
               div_start = 1'b1;
               div_num   = num_t[31] ? -num_t : num_t;
               div_den   = den[31] ? -den : den;
               negq_in   = num_t[31] ^ den[31];
               state_in  = ST_TDIV;
            end
         end
         ST_TDIV: begin
            if (div_stat.done) state_in = ST_TFIN;
         end
         ST_TFIN: begin
            x2       = negq_ff ? -div_quo : div_quo;
            tt       = r1_ff + x2;
            tterm_in = tt;
            tseen_in = 1'b1;
            value_in = sat18(asr32(tt + 32'd8, 5'd4));
            state_in = ST_OUT;
         end
         // b6 and its square
         ST_P1: begin
            mul_a    = tterm_ff - 32'd4000;
            mul_b    = tterm_ff - 32'd4000;
            b6_in    = tterm_ff - 32'd4000;
            sq_in    = asr32(prod, 5'd12);
            state_in = ST_P2;
         end
         ST_P2: begin
            mul_a    = sx16(b12_ff[15:0]);
            mul_b    = sq_ff;
            r1_in    = asr32(prod, 5'd11);
            state_in = ST_P3;
         end
         ST_P3: begin
            mul_a    = sx16(ac12_ff[15:0]);
            mul_b    = b6_ff;
            r1_in    = r1_ff + asr32(prod, 5'd11);
            state_in = ST_P4;
         end
         ST_P4: begin
            b3_sum   = (sx16(ac12_ff[31:16]) << 2) + r1_ff;
            b3_in    = asr32((b3_sum << oss_ff) + 32'd2, 5'd2);
            state_in = ST_P5;
         end
         ST_P5: begin
            mul_a    = {13'd0, raw_ff} - b3_ff;
            mul_b    = 32'd50000 >> oss_ff;
            b7_in    = prod;
            state_in = ST_P6;
         end
         ST_P6: begin
            mul_a    = sx16(ac34_ff[31:16]);
            mul_b    = b6_ff;
            r1_in    = asr32(prod, 5'd13);
            state_in = ST_P7;
         end
         ST_P7: begin
            mul_a    = sx16(b12_ff[31:16]);
            mul_b    = sq_ff;
            r1_in    = asr32(r1_ff + asr32(prod, 5'd16) + 32'd2, 5'd2);
            state_in = ST_P8;
         end
         ST_P8: begin
            mul_a    = {16'd0, ac34_ff[15:0]};
            mul_b    = r1_ff + 32'd32768;
            b4_in    = prod >> 15;
            state_in = ST_P9;
         end
         ST_P9: begin
            if (b4_ff == '0) begin
               status_in = STATUS_DIV0;
               state_in  = ST_OUT;
            end else begin
               // top bit set: divide first, double after, to stay in 32 bits
               div_start = 1'b1;
               div_num   = b7_ff[31] ? b7_ff : {b7_ff[30:0], 1'b0};
               div_den   = b4_ff;
               dbl_in    = b7_ff[31];
               state_in  = ST_PDIV;
            end
         end
         ST_PDIV: begin
            if (div_stat.done) begin
               p_in     = dbl_ff ? {div_quo[30:0], 1'b0} : div_quo;
               state_in = ST_P10;
            end
         end
         ST_P10: begin
            mul_a    = asr32(p_ff, 5'd8);
            mul_b    = asr32(p_ff, 5'd8);
            r1_in    = prod;
            state_in = ST_P11;
         end
         ST_P11: begin
            mul_a    = r1_ff;
            mul_b    = 32'd3038;
            r1_in    = asr32(prod, 5'd16);
            state_in = ST_P12;
         end
         ST_P12: begin
            mul_a    = -32'd7357;
            mul_b    = p_ff;
            pnew     = p_ff + asr32(r1_ff + asr32(prod, 5'd16) + 32'd3791, 5'd4);
            value_in = sat18(pnew);
            state_in = ST_OUT;
         end
         ST_OUT: begin
            rsp_tvalid = 1'b1;
            if (rsp_tready) state_in = ST_IDLE;
         end
         default: state_in = ST_IDLE;
      endcase
   end

   always_ff @(posedge clock) begin
      r1_ff     <= r1_in;
      b6_ff     <= b6_in;
      sq_ff     <= sq_in;
      b3_ff     <= b3_in;
      b7_ff     <= b7_in;
      b4_ff     <= b4_in;
      p_ff      <= p_in;
      negq_ff   <= negq_in;
      dbl_ff    <= dbl_in;
      kind_ff   <= kind_in;
      raw_ff    <= raw_in;
      value_ff  <= value_in;
      status_ff <= status_in;
      if (reset) begin
         state_ff <= ST_IDLE;
         tterm_ff <= '0;
         tseen_ff <= 1'b0;
      end else begin
         state_ff <= state_in;
         tterm_ff <= tterm_in;
         tseen_ff <= tseen_in;
      end
   end

   // value forced to zero whenever a status is flagged
   assign rsp_tdata = {6'd0, (status_ff == STATUS_OK) ? value_ff : 18'd0};
   assign rsp_tuser = {status_ff, kind_ff};

endmodule
`default_nettype wire

### hdl/ptc_chk.sv
`default_nettype none
module ptc_chk (
   input wire logic        clock,
   input wire logic        reset,
   input wire logic        req_tvalid,
   input wire logic        req_tready,
   input wire logic        rsp_tvalid,
   input wire logic        rsp_tready,
   input wire logic [23:0] rsp_tdata,
   input wire logic [2:0]  rsp_tuser
);
   import ptc_pkg::*;

   a_rsp_hold: assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid && !rsp_tready |=> rsp_tvalid)
      else $error("result dropped while stalled");

   a_busy_after_accept: assert property (@(posedge clock) disable iff (reset)
      req_tvalid && req_tready |=> !req_tready)
      else $error("accepted a second item while busy");

   a_no_overlap: assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid |-> !req_tready)
      else $error("input ready while a result is pending");

   a_status_zero: assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid && rsp_tuser[2:1] != STATUS_OK |-> rsp_tdata[17:0] == 18'd0)
      else $error("flagged result carries a value");

   a_status_code: assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid |-> rsp_tuser[2:1] != 2'd3 && !(rsp_tuser[2:1] == STATUS_NO_TMP && !rsp_tuser[0]))
      else $error("bad status for result kind");

endmodule

bind pressure_temp_compensation ptc_chk u_ptc_chk (
   .clock      (clock),
   .reset      (reset),
   .req_tvalid (req_tvalid),
   .req_tready (req_tready),
   .rsp_tvalid (rsp_tvalid),
   .rsp_tready (rsp_tready),
   .rsp_tdata  (rsp_tdata),
   .rsp_tuser  (rsp_tuser)
);
`default_nettype wire

### dv/ptc_checker.sv
`timescale 1ns / 1ps
`default_nettype none
module ptc_checker (
   input  wire logic        clock,
   input  wire logic        reset,
   input  wire logic        req_tvalid,
   input  wire logic        req_tready,
   input  wire logic [23:0] req_tdata,
   input  wire logic [0:0]  req_tuser,
   input  wire logic        rsp_tvalid,
   input  wire logic        rsp_tready,
   input  wire logic [23:0] rsp_tdata,
   input  wire logic [2:0]  rsp_tuser,
   input  wire logic        csr_psel,
   input  wire logic        csr_penable,
   input  wire logic        csr_pwrite,
   input  wire logic [ptc_pkg::AddrWidth-1:0] csr_paddr,
   input  wire logic [31:0] csr_pwdata,
   output int               fail_count,
   output int               pending
);
   import ptc_pkg::*;

   typedef struct packed {
      logic        kind;
      logic [17:0] value;
      logic [1:0]  status;
   } reading_t;

   reading_t    awaited_q[$];
   logic [31:0] cal [8];
   logic [31:0] t_term;
   logic        t_valid;

   function automatic logic [31:0] ext16(input logic [31:0] v);
      return {{16{v[15]}}, v[15:0]};
   endfunction

   function automatic logic [31:0] shr(input logic [31:0] x, input int s);
      return 32'($signed(x) >>> s);
   endfunction

   function automatic logic [17:0] clip18(input logic [31:0] x);
      if ($signed(x) > 32'sd131071) return 18'h1FFFF;
      if ($signed(x) < -32'sd131072) return 18'h20000;
      return x[17:0];
   endfunction

   // compensation of one sample; a temperature sample with a nonzero divisor updates the stored temperature term
   function automatic reading_t compensate(input logic cmd, input logic [18:0] raw);
      reading_t r;
      logic [31:0] x1, x2, x3, den, q, b6, sq, b3, b7, b4, p, ua, ub, num;
      logic [1:0]  oss;
      r.kind = cmd; r.value = '0; r.status = STATUS_OK;
      if (!cmd) begin
         x1 = shr(({16'd0, raw[15:0]} - cal[REG_AC6]) * cal[REG_AC5], 15);
         den = x1 + ext16(cal[REG_MD]);
         if (den == 0) begin
            r.status = STATUS_DIV0;
         end else begin
            num = ext16(cal[REG_MC]) << 11;
            ua = num[31] ? -num : num;
            ub = den[31] ? -den : den;
            q = ua / ub;
            if (num[31] != den[31]) q = -q;
            t_term = x1 + q;
            t_valid = 1'b1;
            r.value = clip18(shr(t_term + 32'd8, 4));
         end
      end else if (!t_valid) begin
         r.status = STATUS_NO_TMP;
      end else begin
         oss = cal[REG_OSS][1:0];
         b6 = t_term - 32'd4000;
         sq = shr(b6 * b6, 12);
         x1 = shr(ext16(cal[REG_B12]) * sq, 11);
         x2 = shr(ext16(cal[REG_AC12]) * b6, 11);
         x3 = x1 + x2;
         b3 = shr(((ext16(cal[REG_AC12] >> 16) * 32'd4 + x3) << oss) + 32'd2, 2);
         b7 = ({13'd0, raw} - b3) * (32'd50000 >> oss);
         x1 = shr(ext16(cal[REG_AC34] >> 16) * b6, 13);
         x2 = shr(ext16(cal[REG_B12] >> 16) * sq, 16);
         x3 = shr(x1 + x2 + 32'd2, 2);
         b4 = ({16'd0, cal[REG_AC34][15:0]} * (x3 + 32'd32768)) >> 15;
         if (b4 == 0) begin
            r.status = STATUS_DIV0;
         end else begin
            p = b7[31] ? (b7 / b4) * 32'd2 : (b7 * 32'd2) / b4;
            x1 = shr(p, 8) * shr(p, 8);
            x1 = shr(x1 * 32'd3038, 16);
            x2 = shr(-32'd7357 * p, 16);
            p = p + shr(x1 + x2 + 32'd3791, 4);
            r.value = clip18(p);
         end
      end
      return r;
   endfunction

   assign pending = awaited_q.size();

   always_ff @(posedge clock) begin
      reading_t seen, want;
      if (reset) begin
         for (int i = 0; i < 8; i++) cal[i] <= '0;
         t_term <= '0; t_valid <= 1'b0;
         fail_count <= 0;
         awaited_q.delete();
      end else begin
         if (csr_psel && csr_penable && csr_pwrite) begin
            case (csr_paddr[4:2])
               REG_OSS:                cal[REG_OSS] <= {30'd0, csr_pwdata[1:0]};
               REG_AC5, REG_AC6, REG_MC, REG_MD:
                  cal[csr_paddr[4:2]] <= {16'd0, csr_pwdata[15:0]};
               default:                cal[csr_paddr[4:2]] <= csr_pwdata;
            endcase
         end
         if (req_tvalid && req_tready)
            awaited_q.push_back(compensate(req_tuser[0], req_tdata[18:0]));
         if (rsp_tvalid && rsp_tready) begin
            seen = {rsp_tuser[0], rsp_tdata[17:0], rsp_tuser[2:1]};
            if (awaited_q.size() == 0) begin
               $display("%0t: unexpected item kind=%0d value=%0d status=%0d", $time,
                        seen.kind, $signed(seen.value), seen.status);
               fail_count <= fail_count + 1;
            end else begin
               want = awaited_q.pop_front();
               if (seen != want || rsp_tdata[23:18] != 0 || rsp_tuser != {seen.status, seen.kind}) begin
                  $display("%0t: mismatch expected kind=%0d value=%0d status=%0d, got kind=%0d value=%0d status=%0d (tdata %h)",
                           $time, want.kind, $signed(want.value), want.status,
                           seen.kind, $signed(seen.value), seen.status, rsp_tdata);
                  fail_count <= fail_count + 1;
               end
            end
         end
      end
   end

endmodule
`default_nettype wire

### dv/tb.sv
`timescale 1ns / 1ps
`default_nettype none
module tb;
   import ptc_pkg::*;

   logic        clock = 1'b0;
   logic        reset = 1'b1;
   logic        req_tvalid = 1'b0;
   logic        req_tready;
   logic [23:0] req_tdata = '0;
   logic [0:0]  req_tuser = '0;
   logic        rsp_tvalid;
   logic        rsp_tready = 1'b0;
   logic [23:0] rsp_tdata;
   logic [2:0]  rsp_tuser;
   logic        csr_psel = 1'b0;
   logic        csr_penable = 1'b0;
   logic        csr_pwrite = 1'b0;
   logic [AddrWidth-1:0] csr_paddr = '0;
   logic [31:0] csr_pwdata = '0;
   logic [31:0] csr_prdata;
   logic        csr_pready;
   int          fail_count;
   int          pending;
   int          send_idle_pct = 0;
   int          recv_idle_pct = 0;
   int          n_sent = 0;

   always #2 clock = ~clock;

   pressure_temp_compensation i_dut (.*);

   ptc_checker i_checker (.*);

   // receiver back-pressure, re-rolled every falling edge
   always @(negedge clock)
      rsp_tready <= ($urandom_range(99) >= recv_idle_pct);

   // APB write: setup then access
   task automatic write_reg(input logic [2:0] idx, input logic [31:0] val);
      csr_psel = 1'b1; csr_pwrite = 1'b1; csr_penable = 1'b0;
      csr_paddr = {idx, 2'b00}; csr_pwdata = val;
      @(negedge clock);
      csr_penable = 1'b1;
      do @(posedge clock); while (!csr_pready);
      @(negedge clock);
      csr_psel = 1'b0; csr_penable = 1'b0; csr_pwrite = 1'b0;
   endtask

   // drain results, then let the sequencer settle before touching registers
   task automatic wait_idle();
      while (pending != 0) @(negedge clock);
      repeat (60) @(negedge clock);
   endtask

   // one item; valid held until the handshake, gaps before it at random
   task automatic send_sample(input logic cmd, input logic [18:0] raw);
      while ($urandom_range(99) < send_idle_pct) @(negedge clock);
      req_tvalid = 1'b1; req_tuser = cmd; req_tdata = {5'd0, raw};
      do @(posedge clock); while (!req_tready);
      @(negedge clock);
      req_tvalid = 1'b0;
      n_sent++;
   endtask

   // typical datasheet calibration with random jitter, oss random
   task automatic load_typical_cal();
      write_reg(REG_OSS, $urandom_range(3));
      write_reg(REG_AC12, {16'd408 + 16'($urandom_range(200)), -16'sd72});
      write_reg(REG_AC34, {-16'sd14383, 16'd32741 + 16'($urandom_range(500))});
      write_reg(REG_AC5, 32'd32757 - $urandom_range(2000));
      write_reg(REG_AC6, 32'd23153 + $urandom_range(2000));
      write_reg(REG_B12, {16'd6190, 16'd4});
      write_reg(REG_MC, {16'd0, -16'sd8711});
      write_reg(REG_MD, 32'd2868);
   endtask

   task automatic random_cal();
      for (int i = 0; i < 8; i++) write_reg(i[2:0], $urandom());
   endtask

   // mostly plausible readings, some full-range noise
   task automatic random_item();
      logic [18:0] raw;
      if ($urandom_range(9) < 7) raw = 19'(20000 + $urandom_range(20000) << ($urandom_range(3)));
      else raw = 19'($urandom());
      send_sample($urandom_range(2) == 0 ? 1'b0 : 1'b1, raw);
   endtask

   initial begin
      repeat (7) @(posedge clock);
      @(negedge clock);
      reset <= 1'b0;
      send_idle_pct = 11; recv_idle_pct = 88;

      // all-zero calibration: pressure with no temperature yet, then a
      // temperature whose divisor is zero
      send_sample(1'b1, 19'h7FFFF);
      send_sample(1'b0, 19'd0);
      send_sample(1'b1, 19'd12345);
      wait_idle();

      load_typical_cal();
      send_sample(1'b1, 19'd0);            // still no temperature stored
      send_sample(1'b0, 19'h7FFFF);        // wide sample, upper bits dropped
      send_sample(1'b0, 19'd27898);
      send_sample(1'b1, 19'd23843);
      send_sample(1'b1, 19'd0);
      send_sample(1'b1, 19'h7FFFF);
      send_sample(1'b0, 19'h0FFFF);
      send_sample(1'b1, 19'h40000);
      send_sample(1'b0, 19'd0);
      send_sample(1'b1, 19'd50000);
      wait_idle();

      // extreme registers: oversampling 3, huge slopes to force saturation
      write_reg(REG_OSS, 32'd3);
      write_reg(REG_AC5, 32'hFFFF);
      write_reg(REG_AC6, 32'd0);
      write_reg(REG_MC, 32'h7FFF);
      write_reg(REG_MD, 32'h8000);
      send_sample(1'b0, 19'hFFFF);
      send_sample(1'b1, 19'd100);
      wait_idle();
      write_reg(REG_OSS, 32'd0);
      write_reg(REG_AC34, 32'h80000000);   // ac4 zero: pressure divisor zero
      send_sample(1'b1, 19'd40000);
      send_sample(1'b0, 19'd0);
      wait_idle();

      // random phases: three idling profiles, calibration changed between them
      for (int phase = 0; phase < 12; phase++) begin
         send_idle_pct = (phase < 4) ? 11 : (phase < 8) ? 88 : 0;
         recv_idle_pct = (phase < 4) ? 88 : (phase < 8) ? 11 : 0;
         if (phase % 3 == 2) random_cal(); else load_typical_cal();
         for (int k = 0; k < 60; k++) begin
            random_item();
            // hold off once per phase until every result is back
            if (k == 30) while (pending != 0) @(negedge clock);
         end
         wait_idle();
      end
   end

   // verdict once all stimulus is done
   initial begin
      wait (n_sent >= 737);
      while (pending != 0) @(negedge clock);
      repeat (100) @(negedge clock);
      $display("Sent %0d samples of both kinds over typical, random and extreme",
               n_sent);
      $display("calibrations, all oversampling settings and three idling profiles.");
      if (fail_count == 0) begin
         $display("Test completed successfully");
      end else begin
         $display("Test completed with failures");
      end
      $finish;
   end

   initial begin
      #4000000;
      $display("Test completed with failures");
      $finish;
   end

endmodule
`default_nettype wire
